FILE: design/ewpt_pkg.sv
package ewpt_pkg;

	localparam int SAMPLE_W = 16;
	localparam int VEL_W = 16;
	localparam int COUNT_W = 21;
	localparam int VNUM_W = 32;
	localparam int VMAG_W = VNUM_W - 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] OPT_MAX_RESET = 21'h100000;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = COUNT_W;
	localparam logic [CFG_IDX_W-1:0] CFG_ALT_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPT_MAX = 1'd1;

endpackage

FILE: design/ewpt_in_if.sv
interface ewpt_in_if import ewpt_pkg::*; ();
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] timer_count;

	modport source (output valid, output timer_count, input ready);
	modport sink (input valid, input timer_count, output ready);
endinterface

FILE: design/ewpt_out_if.sv
interface ewpt_out_if import ewpt_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VEL_W-1:0] velocity;
	logic [COUNT_W-1:0] abs_count;
	logic below_zero;

	modport source (output valid, output velocity, output abs_count, output below_zero,
		input ready);
	modport sink (input valid, input velocity, input abs_count, input below_zero,
		output ready);
endinterface

FILE: design/ewpt_vel_div.sv
module ewpt_vel_div import ewpt_pkg::*; #(
	parameter int CALC_PERIOD = 10
) (
	input  logic neg,
	input  logic [VMAG_W-1:0] mag,
	output logic signed [VEL_W-1:0] velocity
);

	// Magnitudes past CLAMP saturate anyway, so the quotient only has to be exact
	// below 2^DIV_N, which lets one reciprocal multiply replace the divider.
	localparam int DIV_N = 25;
	localparam int DIV_L = $clog2(CALC_PERIOD);
	localparam int DIV_S = DIV_N + DIV_L;
	localparam longint CLAMP_L = 64'd32768 * CALC_PERIOD;
	localparam longint RECIP_L = ((64'd1 << DIV_S) + CALC_PERIOD - 1) / CALC_PERIOD;
	localparam int RECIP_W = DIV_N + 2;
	localparam int PROD_W = DIV_N + RECIP_W;
	localparam int Q_W = VEL_W + 1;

	localparam logic [DIV_N-1:0] CLAMP = DIV_N'(CLAMP_L);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(32767);
	localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(32768);

	logic [DIV_N-1:0] mag_c;
	logic [PROD_W-1:0] prod;
	logic [Q_W-1:0] quot;
	logic [Q_W-1:0] neg_quot;

	always_comb begin
		if (mag > VMAG_W'(CLAMP)) begin
			mag_c = CLAMP;
		end else begin
			mag_c = mag[DIV_N-1:0];
		end
		prod = PROD_W'(mag_c) * PROD_W'(RECIP);
		quot = prod[DIV_S +: Q_W];
		neg_quot = Q_W'(0) - quot;
		if (neg) begin
			if (quot >= NEG_LIMIT) begin
				velocity = {1'b1, {(VEL_W-1){1'b0}}};
			end else begin
				velocity = neg_quot[VEL_W-1:0];
			end
		end else begin
			if (quot > POS_LIMIT) begin
				velocity = {1'b0, {(VEL_W-1){1'b1}}};
			end else begin
				velocity = quot[VEL_W-1:0];
			end
		end
	end

endmodule

FILE: design/encoder_wrap_position_tracker.sv
// Encoder wrap and position tracker.
// The accepting edge loads the tracking state and the velocity numerator register;
// the result register loads as that stage advances, which output back-pressure can hold.
// Throughput: one item per cycle unless the output stalls; wrap/sample state updates on accept.
// Reset clears the sample, wrap counter, below-zero flag and pipeline valids, and
// loads the configuration defaults (plain count mode, optical maximum 1048576).
module encoder_wrap_position_tracker import ewpt_pkg::*; #(
	parameter int TIMER_PERIOD = 65536,
	parameter int HALF_PERIOD = 32768,
	parameter int WRAP_MAX = 16,
	parameter int CALC_PERIOD = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ewpt_in_if.sink in_ch,
	ewpt_out_if.source out_ch
);

	localparam int WRAP_W = (WRAP_MAX > 2) ? $clog2(WRAP_MAX) : 1;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int CPROD_W = WRAP_W + VNUM_W;
	localparam int ALT_W = VNUM_W + 2;
	localparam logic [WRAP_W-1:0] WRAP_TOP = WRAP_W'(WRAP_MAX - 1);
	localparam logic [VNUM_W-1:0] PERIOD_V = VNUM_W'(TIMER_PERIOD);
	localparam logic [VNUM_W-1:0] HALF_V = VNUM_W'(HALF_PERIOD);

	// Configuration
	logic alt_mode_q;
	logic [COUNT_W-1:0] opt_max_q;

	// Tracking state
	logic [SAMPLE_W-1:0] last_q;
	logic [WRAP_W-1:0] wrap_q;
	logic flag_q;

	// First stage
	logic valid_s1;
	logic vneg_s1;
	logic [VMAG_W-1:0] vmag_s1;
	logic [SAMPLE_W-1:0] samp_s1;
	logic [WRAP_W-1:0] wrap_s1;
	logic flag_s1;

	// Result register
	logic out_valid_q;
	logic signed [VEL_W-1:0] vel_q;
	logic [COUNT_W-1:0] count_q;
	logic below_q;

	logic in_acc;
	logic s1_adv;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] mag;
	logic moved;
	logic wrap_hit;
	logic signed [VNUM_W-1:0] span;
	logic signed [VNUM_W-1:0] vnum;
	logic signed [VNUM_W-1:0] vnum_abs;
	logic [SAMPLE_W-1:0] last_d;
	logic [WRAP_W-1:0] wrap_d;
	logic flag_d;

	logic signed [VEL_W-1:0] vel_d;
	logic [CPROD_W-1:0] cnt_norm;
	logic signed [ALT_W-1:0] cnt_alt;
	logic [COUNT_W-1:0] count_d;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign s1_adv = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || s1_adv;

	always_comb begin
		diff = $signed({1'b0, in_ch.timer_count}) - $signed({1'b0, last_q});
		mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
		moved = (diff != '0);
		wrap_hit = moved && ({{(VNUM_W-DIFF_W){1'b0}}, mag} > HALF_V);
		span = $signed(PERIOD_V) - $signed({{(VNUM_W-DIFF_W){1'b0}}, mag});
		vnum = VNUM_W'(diff);
		last_d = moved ? in_ch.timer_count : last_q;
		wrap_d = wrap_q;
		flag_d = flag_q;
		if (wrap_hit) begin
			if (!diff[DIFF_W-1]) begin
				// Timer jumped forward over half a period: it wrapped backward.
				vnum = -span;
				if (wrap_q != '0) begin
					wrap_d = wrap_q - WRAP_W'(1);
				end else begin
					wrap_d = WRAP_TOP;
					flag_d = 1'b1;
				end
			end else begin
				vnum = span;
				if (wrap_q == WRAP_TOP) begin
					wrap_d = '0;
					flag_d = 1'b0;
				end else begin
					wrap_d = wrap_q + WRAP_W'(1);
				end
			end
		end
		vnum_abs = vnum[VNUM_W-1] ? -vnum : vnum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_mode_q <= 1'b0;
			opt_max_q <= OPT_MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALT_MODE: alt_mode_q <= cfg_data[0];
				CFG_OPT_MAX: opt_max_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			wrap_q <= '0;
			flag_q <= 1'b0;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				last_q <= last_d;
				wrap_q <= wrap_d;
				flag_q <= flag_d;
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Each stage captures the state as it stands after its own item.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			vneg_s1 <= vnum[VNUM_W-1];
			vmag_s1 <= vnum_abs[VMAG_W-1:0];
			samp_s1 <= last_d;
			wrap_s1 <= wrap_d;
			flag_s1 <= flag_d;
		end
		if (s1_adv) begin
			vel_q <= vel_d;
			count_q <= count_d;
			below_q <= flag_s1;
		end
	end

	ewpt_vel_div #(
		.CALC_PERIOD(CALC_PERIOD)
	) u_vel_div (
		.neg(vneg_s1),
		.mag(vmag_s1),
		.velocity(vel_d)
	);

	always_comb begin
		cnt_norm = CPROD_W'(wrap_s1) * CPROD_W'(PERIOD_V) + CPROD_W'(samp_s1);
		cnt_alt = $signed(ALT_W'(opt_max_q)) - $signed(ALT_W'(PERIOD_V))
			+ $signed(ALT_W'(samp_s1));
		if (alt_mode_q && flag_s1) begin
			if (cnt_alt[ALT_W-1]) begin
				count_d = '0;
			end else if (cnt_alt > $signed(ALT_W'(COUNT_MAX))) begin
				count_d = COUNT_MAX;
			end else begin
				count_d = cnt_alt[COUNT_W-1:0];
			end
		end else begin
			if (cnt_norm > CPROD_W'(COUNT_MAX)) begin
				count_d = COUNT_MAX;
			end else begin
				count_d = cnt_norm[COUNT_W-1:0];
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.velocity = vel_q;
	assign out_ch.abs_count = count_q;
	assign out_ch.below_zero = below_q;

endmodule
